// ----- src/sfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, constants and lookup functions of the segment frame packer.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int NUM_DIGITS  = 18;
  localparam int FRAME_BYTES = 16;
  localparam int GLYPH_COUNT = 39;

  typedef logic [5:0] char_code_t;
  typedef logic [6:0] seg_mask_t;
  typedef logic [4:0] digit_idx_t;
  typedef logic [3:0] byte_idx_t;

  localparam char_code_t CODE_BLANK = 6'd38;
  localparam byte_idx_t  LAST_BYTE  = 4'(FRAME_BYTES - 1);
  localparam byte_idx_t  DOT_BYTE   = 4'd3;

  // Command codes carried on the func field
  typedef enum logic [1:0] {
    FUNC_WRITE_DIGIT = 2'd0,
    FUNC_SET_DOTS    = 2'd1,
    FUNC_DRAW        = 2'd2
  } func_t;

  // Snapshot of the display state taken by a draw command
  typedef struct packed {
    logic [NUM_DIGITS-1:0][5:0] codes;
    logic [1:0]                 dots;   // bit 0 left dot, bit 1 right dot
  } draw_job_t;

  // Source of one frame byte: low bits from digit_a, high bits from digit_b
  typedef struct packed {
    digit_idx_t digit_a;
    digit_idx_t digit_b;
    logic [2:0] shift;
  } byte_src_t;

  // Seven-segment character table: digits, letters, minus, all on, blank
  localparam seg_mask_t GLYPH_ROM [GLYPH_COUNT] = '{
    7'h5F, 7'h50, 7'h3B, 7'h79, 7'h74, 7'h6D, 7'h6F, 7'h58, 7'h7F, 7'h7D,
    7'h7E, 7'h67, 7'h0F, 7'h73, 7'h2F, 7'h2E, 7'h4F, 7'h76, 7'h06, 7'h51,
    7'h01, 7'h07, 7'h01, 7'h62, 7'h63, 7'h3E, 7'h01, 7'h01, 7'h6D, 7'h27,
    7'h43, 7'h01, 7'h01, 7'h01, 7'h01, 7'h3B,
    7'h20, 7'h7F, 7'h00
  };

  // Map a character code to its segment mask; codes without a glyph go blank
  function automatic seg_mask_t glyph(input char_code_t code);
    seg_mask_t m;
    m = 7'h00;
    if (code < 6'(GLYPH_COUNT)) begin
      m = GLYPH_ROM[code];
    end
    return m;
  endfunction

  // Glass wiring: each frame byte holds the top bits of one digit mask
  // followed by the low bits of the next digit in the stream
  function automatic byte_src_t byte_source(input byte_idx_t idx);
    byte_src_t s;
    unique case (idx)
      4'd0:    s = '{5'd13, 5'd14, 3'd5};
      4'd1:    s = '{5'd14, 5'd15, 3'd6};
      4'd2:    s = '{5'd16, 5'd17, 3'd0};
      4'd3:    s = '{5'd17, 5'd17, 3'd1};
      4'd4:    s = '{5'd9,  5'd10, 3'd1};
      4'd5:    s = '{5'd10, 5'd11, 3'd2};
      4'd6:    s = '{5'd11, 5'd12, 3'd3};
      4'd7:    s = '{5'd12, 5'd13, 3'd4};
      4'd8:    s = '{5'd4,  5'd5,  3'd4};
      4'd9:    s = '{5'd5,  5'd6,  3'd5};
      4'd10:   s = '{5'd6,  5'd7,  3'd6};
      4'd11:   s = '{5'd8,  5'd9,  3'd0};
      4'd12:   s = '{5'd0,  5'd1,  3'd0};
      4'd13:   s = '{5'd1,  5'd2,  3'd1};
      4'd14:   s = '{5'd2,  5'd3,  3'd2};
      4'd15:   s = '{5'd3,  5'd4,  3'd3};
      default: s = '{5'd0,  5'd0,  3'd0};
    endcase
    return s;
  endfunction

endpackage

// ----- src/sfp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_front
// Accepts command items, keeps digit codes and dot flags, queues draw jobs.
// ----------------------------------------------------------------------------
module sfp_front import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [4:0] in_position,
  input  logic [5:0] in_char_code,
  input  logic       in_dot_left,
  input  logic       in_dot_right,
  input  logic       q_full,
  output logic       q_push,
  output draw_job_t  q_job
);

  logic [NUM_DIGITS-1:0][5:0] codes_r;
  logic [1:0]                 dots_r;
  logic                       accept;
  func_t                      func;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign func     = func_t'(in_func);

  // Push a snapshot on a draw
  assign q_push      = accept && (func == FUNC_DRAW);
  assign q_job.codes = codes_r;
  assign q_job.dots  = dots_r;

  // Update digit codes and dot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        codes_r[i] <= CODE_BLANK;
      end
      dots_r <= 2'b00;
    end else if (accept) begin
      case (func)
        FUNC_WRITE_DIGIT: begin
          if (in_position < 5'(NUM_DIGITS)) begin
            codes_r[in_position] <= in_char_code;
          end
        end
        FUNC_SET_DOTS: begin
          dots_r <= {in_dot_right, in_dot_left};
        end
        default: begin
          // draw is queued, unused code is dropped
        end
      endcase
    end
  end

endmodule

// ----- src/sfp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_queue
// Two-entry queue of draw jobs between the command front and byte back end.
// ----------------------------------------------------------------------------
module sfp_queue import sfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  draw_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output draw_job_t head_job
);

  draw_job_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = slot_r[rd_ptr_r];

  // Store a pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- src/sfp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_back
// Walks the 16 frame bytes of the head draw job into the output register.
// ----------------------------------------------------------------------------
module sfp_back import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  draw_job_t  head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [3:0] out_byte_index,
  output logic       out_last_byte
);

  byte_idx_t  cnt_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  byte_idx_t  index_r;
  logic       last_r;

  byte_src_t  src;
  seg_mask_t  mask_a;
  seg_mask_t  mask_b;
  logic [7:0] lo_part;
  logic [14:0] hi_wide;
  logic [7:0] byte_nxt;
  logic       load;

  // Assemble the byte for the current count
  always_comb begin
    src     = byte_source(cnt_r);
    mask_a  = glyph(head_job.codes[src.digit_a]);
    mask_b  = glyph(head_job.codes[src.digit_b]);
    lo_part = {1'b0, mask_a} >> src.shift;
    hi_wide = {8'b0, mask_b} << (3'd7 - src.shift);
    if (cnt_r == DOT_BYTE) begin
      byte_nxt = {head_job.dots[0], head_job.dots[1], lo_part[5:0]};
    end else begin
      byte_nxt = lo_part | hi_wide[7:0];
    end
  end

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && (cnt_r == LAST_BYTE);

  // Advance the byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cnt_r       <= cnt_r + 4'd1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      index_r <= cnt_r;
      last_r  <= (cnt_r == LAST_BYTE);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_byte_index = index_r;
  assign out_last_byte  = last_r;

endmodule

// ----- src/segment_frame_packer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_frame_packer_unit
// Frame builder for an 18-digit seven-segment glass driver.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes command items: write a digit
// code, set the two dot flags, or draw a frame. Writes and dot sets give
// no result; a digit write to a position past the last digit and the
// unused command code are dropped.
// A draw snapshots the digit codes and dots into a two-entry job queue. The
// back end then emits 16 result items (out_valid / out_stall), one frame byte
// per cycle in byte order while the receiver does not stall, byte 15 marked
// last so the load strobe can follow. A draw passes through the job queue
// and then the output register before its first byte shows, and occupies
// the back end for its walk through the frame. Commands keep flowing while
// up to two draws wait or run; in_stall rises only when the job queue is
// full. When the receiver stalls, the output register holds its byte and the
// walk pauses. Synchronous reset blanks all digits, clears the dots, empties
// the queue and drops any pending result.
// ----------------------------------------------------------------------------
module segment_frame_packer_unit import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [4:0] in_position,
  input  logic [5:0] in_char_code,
  input  logic       in_dot_left,
  input  logic       in_dot_right,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [3:0] out_byte_index,
  output logic       out_last_byte
);

  logic      q_full;
  logic      q_push;
  draw_job_t q_job;
  logic      q_pop;
  logic      q_head_valid;
  draw_job_t q_head_job;

  // Classify commands and keep display state
  sfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_char_code (in_char_code),
    .in_dot_left  (in_dot_left),
    .in_dot_right (in_dot_right),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // Buffer draw jobs
  sfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Emit frame bytes
  sfp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_job       (q_head_job),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ----- src/sfp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks of the segment frame packer, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker import sfp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic [3:0] out_byte_index,
  input logic       out_last_byte
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte)
      && $stable(out_byte_index) && $stable(out_last_byte))
    else $error("stalled result changed");

  // Mark only the final byte of a frame as last
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_byte == (out_byte_index == LAST_BYTE)))
    else $error("last flag does not match byte index");

  // Stream a frame without gaps once it has started
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_byte |=>
      out_valid && (out_byte_index == $past(out_byte_index) + 4'd1))
    else $error("frame bytes out of sequence");

  // Drop any result at reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Open the input once the queue is emptied by reset
  assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind segment_frame_packer_unit sfp_checker u_sfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_byte_index (out_byte_index),
  .out_last_byte  (out_last_byte)
);
